FILE: rtl/jbce_pkg.sv
// shared widths, bit positions and the result record of the jtag byte command engine
`timescale 1ns / 1ps

package jbce_pkg;

   localparam int ByteWidth  = 8;
   localparam int CountWidth = 6;
   localparam int ReqWidth   = 16;
   localparam int RspWidth   = 24;
   localparam int RspUsed    = 22;

   localparam logic [ByteWidth-1:0]  ShiftFlagMask = 8'h80;
   localparam logic [ByteWidth-1:0]  PinMask       = 8'h7F;
   localparam logic [ByteWidth-1:0]  ModeMask      = 8'h60;
   localparam logic [CountWidth-1:0] CountMask     = 6'h3F;

   localparam int BitShift = 7;
   localparam int BitRead  = 6;
   localparam int BitLed   = 5;
   localparam int BitTdi   = 4;
   localparam int BitTms   = 1;
   localparam int BitTck   = 0;

   typedef struct packed {
      logic [ByteWidth-1:0] read_data;
      logic                 read_valid;
      logic [ByteWidth-1:0] shift_out;
      logic                 shift_now;
      logic                 led_level;
      logic                 tck_level;
      logic                 tms_level;
      logic                 tdi_level;
   } result_type;

   typedef struct packed {
      logic [ByteWidth-1:0] tdo_bits;
      logic [ByteWidth-1:0] command_byte;
   } command_item_type;

endpackage

FILE: rtl/jbce_in_stage.sv
// input register of the request stream
`timescale 1ns / 1ps

module jbce_in_stage
   import jbce_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  command_item_type req_item,
   input  logic             advance,
   output logic             item_valid,
   output command_item_type item
);

   logic             valid_ff;
   logic             valid_in;
   command_item_type item_ff;

   assign req_tready = !valid_ff || advance;
   assign valid_in   = req_tready ? req_tvalid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_tready && req_tvalid) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

FILE: rtl/jbce_decode.sv
// command decode with the shift count, read flag and pin registers
`timescale 1ns / 1ps

module jbce_decode
   import jbce_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  command_item_type item,
   output result_type       result
);

   logic [CountWidth-1:0] bytes_left_ff, bytes_left_in;
   logic                  read_enable_ff, read_enable_in;
   logic                  tdi_ff, tdi_in;
   logic                  tms_ff, tms_in;
   logic                  tck_ff, tck_in;
   logic                  led_ff, led_in;

   logic [ByteWidth-1:0] cmd;
   logic [ByteWidth-1:0] tdo;

   assign cmd = item.command_byte;
   assign tdo = item.tdo_bits;

   always_comb begin
      bytes_left_in     = bytes_left_ff;
      read_enable_in    = read_enable_ff;
      tdi_in            = tdi_ff;
      tms_in            = tms_ff;
      tck_in            = tck_ff;
      led_in            = led_ff;
      result.shift_now  = 1'b0;
      result.shift_out  = '0;
      result.read_valid = 1'b0;
      result.read_data  = '0;
      if (bytes_left_ff == '0) begin
         read_enable_in = cmd[BitRead];
         if ((cmd & ShiftFlagMask) != '0) begin
            bytes_left_in = cmd[CountWidth-1:0] & CountMask;
         end else begin
            led_in = ~cmd[BitLed];
            tdi_in = cmd[BitTdi];
            tms_in = cmd[BitTms];
            tck_in = cmd[BitTck];
            if (cmd[BitRead]) begin
               result.read_valid = 1'b1;
               result.read_data  = {{(ByteWidth-1){1'b0}}, tdo[0]};
            end
         end
      end else begin
         bytes_left_in    = (bytes_left_ff - 1'b1) & CountMask;
         result.shift_now = 1'b1;
         result.shift_out = cmd;
         if (read_enable_ff) begin
            result.read_valid = 1'b1;
            result.read_data  = tdo;
         end
      end
      result.tdi_level = tdi_in;
      result.tms_level = tms_in;
      result.tck_level = tck_in;
      result.led_level = led_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff  <= '0;
         read_enable_ff <= 1'b0;
         tdi_ff         <= 1'b0;
         tms_ff         <= 1'b0;
         tck_ff         <= 1'b0;
         led_ff         <= 1'b1;
      end else if (step) begin
         bytes_left_ff  <= bytes_left_in;
         read_enable_ff <= read_enable_in;
         tdi_ff         <= tdi_in;
         tms_ff         <= tms_in;
         tck_ff         <= tck_in;
         led_ff         <= led_in;
      end
   end

endmodule

FILE: rtl/jbce_out_stage.sv
// result register of the response stream
`timescale 1ns / 1ps

module jbce_out_stage
   import jbce_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  result_type          result,
   output logic                advance,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspWidth-1:0] rsp_tdata
);

   logic       valid_ff;
   logic       valid_in;
   logic       room;
   result_type result_ff;

   assign room     = !valid_ff || rsp_tready;
   assign advance  = room && item_valid;
   assign valid_in = room ? item_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(RspWidth-RspUsed){1'b0}}, result_ff};

endmodule

FILE: rtl/jtag_byte_command_engine_top.sv
// top level of the jtag byte command engine
`timescale 1ns / 1ps

// Byte command JTAG engine. Each request byte is either a command (bit 7 opens a
// shift run of bits 5..0 payload bytes, with bit 6 asking for read-back; otherwise
// it bit-bangs TDI, TMS, TCK and the LED) or a payload byte of a pending shift run,
// which survives any gap in the stream. Every request transfer gives exactly one
// response transfer carrying the pin levels after that byte, the byte to shift and
// any read-back data. A byte passes the input register, the decode and the result
// register, so its response is offered once the result register has taken it, and
// one byte is taken every cycle as long as the response side keeps taking results.

module jtag_byte_command_engine_top
   import jbce_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // command_byte [7:0], tdo_bits [15:8]
   input  logic [ReqWidth-1:0] req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // tdi_level [0], tms_level [1], tck_level [2], led_level [3], shift_now [4],
   // shift_out [12:5], read_valid [13], read_data [21:14], zero [23:22]
   output logic [RspWidth-1:0] rsp_tdata
);

   command_item_type req_item;
   command_item_type item;
   logic             item_valid;
   logic             advance;
   result_type       result;

   assign req_item = command_item_type'(req_tdata);

   jbce_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   jbce_decode u_decode (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item),
      .result (result)
   );

   jbce_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .result     (result),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: tb/jtag_byte_command_engine_top_tb.sv
// self-checking testbench of the jtag byte command engine top level
`timescale 1ns / 1ps

module jtag_byte_command_engine_top_tb;
   import jbce_pkg::*;

   localparam int ResultBits = $bits(result_type);
   localparam int CycleLimit = 200000;
   localparam int RandomItems = 1100;
   localparam int HoldStart = 300;
   localparam int HoldCycles = 200;
   localparam int SettleCycles = 10;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqWidth-1:0] req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspWidth-1:0] rsp_tdata;

   command_item_type pending_bytes[$];
   result_type       expected_results[$];

   // engine state as the predictor sees it
   logic [CountWidth-1:0] run_left = '0;
   logic                  run_read = 1'b0;
   logic                  pin_tdi = 1'b0;
   logic                  pin_tms = 1'b0;
   logic                  pin_tck = 1'b0;
   logic                  pin_led = 1'b1;

   int errors = 0;
   int cycles = 0;
   int sent_count = 0;
   int taken_count = 0;
   int bang_count = 0;
   int payload_count = 0;
   int readback_count = 0;
   int send_gap = 0;
   int stall_left = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   jtag_byte_command_engine_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   function automatic result_type decode_byte(input logic [ByteWidth-1:0] cmd,
                                              input logic [ByteWidth-1:0] tdo);
      result_type r;
      r = '0;
      if (run_left == '0) begin
         run_read = cmd[BitRead];
         if (cmd[BitShift]) begin
            run_left = cmd[CountWidth-1:0];
         end else begin
            pin_led = ~cmd[BitLed];
            pin_tdi = cmd[BitTdi];
            pin_tms = cmd[BitTms];
            pin_tck = cmd[BitTck];
            bang_count++;
            if (run_read) begin
               r.read_valid = 1'b1;
               r.read_data  = {7'd0, tdo[0]};
            end
         end
      end else begin
         run_left    = run_left - 1'b1;
         r.shift_now = 1'b1;
         r.shift_out = cmd;
         payload_count++;
         if (run_read) begin
            r.read_valid = 1'b1;
            r.read_data  = tdo;
         end
      end
      if (r.read_valid) readback_count++;
      r.tdi_level = pin_tdi;
      r.tms_level = pin_tms;
      r.tck_level = pin_tck;
      r.led_level = pin_led;
      return r;
   endfunction

   // stretches of full rate alternate with random waits
   function automatic int draw_wait(input int count);
      if ((count % 250) < 50) return 0;
      return $urandom_range(0, 6);
   endfunction

   task automatic add_byte(input logic [ByteWidth-1:0] cmd, input logic [ByteWidth-1:0] tdo);
      command_item_type item;
      item.command_byte = cmd;
      item.tdo_bits     = tdo;
      pending_bytes.push_back(item);
   endtask

   task automatic compare_field(input string name, input int exp, input int act);
      if (exp != act) begin
         $error("%s mismatch: expected %0h, got %0h", name, exp, act);
         errors++;
      end
   endtask

   // driver
   always @(posedge clock) begin
      command_item_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap   <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap > 0) begin
            req_tvalid <= 1'b0;
            send_gap   <= send_gap - 1;
         end else if (pending_bytes.size() > 0) begin
            item = pending_bytes.pop_front();
            req_tdata  <= item;
            req_tvalid <= 1'b1;
            send_gap   <= draw_wait(sent_count);
            sent_count++;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // long receiver hold-off so the engine backs up into its input
   always @(posedge clock) begin
      if (!reset) begin
         if (!hold_done && taken_count >= HoldStart) begin
            hold_left <= HoldCycles;
            hold_done <= 1'b1;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
         end
      end
   end

   // receiver
   always @(posedge clock) begin
      int next_stall;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) next_stall = draw_wait(taken_count + 120);
         else if (stall_left > 0) next_stall = stall_left - 1;
         else next_stall = 0;
         stall_left <= next_stall;
         rsp_tready <= (next_stall == 0) && (hold_left == 0);
      end
   end

   // monitor: predict on each request transfer, check each response transfer
   always @(posedge clock) begin
      command_item_type req;
      result_type       got;
      result_type       exp;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            req = command_item_type'(req_tdata);
            expected_results.push_back(decode_byte(req.command_byte, req.tdo_bits));
         end
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[ResultBits-1:0]);
            taken_count++;
            if (expected_results.size() == 0) begin
               $error("response transfer with no expected result: %h", rsp_tdata);
               errors++;
            end else begin
               exp = expected_results.pop_front();
               compare_field("tdi_level", exp.tdi_level, got.tdi_level);
               compare_field("tms_level", exp.tms_level, got.tms_level);
               compare_field("tck_level", exp.tck_level, got.tck_level);
               compare_field("led_level", exp.led_level, got.led_level);
               compare_field("shift_now", exp.shift_now, got.shift_now);
               compare_field("shift_out", exp.shift_out, got.shift_out);
               compare_field("read_valid", exp.read_valid, got.read_valid);
               compare_field("read_data", exp.read_data, got.read_data);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int count;
      int total;
      int pick;
      // bit-bang extremes, ignored bits, led and read
      add_byte(8'h00, 8'hFF);
      add_byte(8'h7F, 8'hFE);
      add_byte(8'h7F, 8'h01);
      add_byte(8'h3F, 8'hFF);
      add_byte(8'h40, 8'hFF);
      add_byte(8'h0C, 8'h00);
      add_byte(8'h13, 8'h5A);
      add_byte(8'h20, 8'h00);
      add_byte(8'h52, 8'hA5);
      // shift commands with zero count
      add_byte(8'h80, 8'hFF);
      add_byte(8'hC0, 8'hFF);
      add_byte(8'h01, 8'h00);
      // shift with read-back, payload at the extremes
      add_byte(8'hC2, 8'h00);
      add_byte(8'h00, 8'hFF);
      add_byte(8'hFF, 8'hA5);
      // shift without read, payload that looks like commands
      add_byte(8'h83, 8'hFF);
      add_byte(8'h80, 8'h3C);
      add_byte(8'hFF, 8'hC3);
      add_byte(8'hC5, 8'h00);
      add_byte(8'h61, 8'h01);
      total = pending_bytes.size();

      while (total < RandomItems) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            add_byte(8'($urandom_range(0, 127)), 8'($urandom_range(0, 255)));
            total++;
         end else if (pick < 85) begin
            // well-formed shift run, mostly short, sometimes empty or full
            pick = $urandom_range(0, 19);
            if (pick == 0) count = 0;
            else if (pick == 1) count = 63;
            else count = $urandom_range(1, 8);
            add_byte({1'b1, 1'($urandom_range(0, 1)), 6'(count)}, 8'($urandom_range(0, 255)));
            for (int i = 0; i < count; i++)
               add_byte(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            total += count + 1;
         end else begin
            add_byte(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            total++;
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() > 0 || req_tvalid) @(posedge clock);
      while (expected_results.size() > 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);

      $display("%0d bytes sent, %0d results checked, %0d bit-bang, %0d shifted, %0d read back",
               sent_count, taken_count, bang_count, payload_count, readback_count);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches", errors);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
